@@ src/mbph_pkg.sv @@
// Package for the level meter ballistics block: widths, register codes,
// configuration and state types, and coefficient saturation. No dependencies.
package mbph_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int LEVEL_W    = FRAC_BITS + 2;
  localparam int TARGET_W   = LEVEL_W + 1;
  localparam int COEF_W     = FRAC_BITS + 1;
  localparam int HOLD_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COEF_W;

  localparam logic [COEF_W-1:0] COEF_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

  localparam logic [COEF_W-1:0] ATTACK_RST  = COEF_W'(65536);
  localparam logic [COEF_W-1:0] RELEASE_RST = COEF_W'(6554);
  localparam logic [COEF_W-1:0] FALL_RST    = COEF_W'(62259);
  localparam logic [HOLD_W-1:0] HOLD_RST    = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_RELEASE = 2'd1,
    CFG_FALL    = 2'd2,
    CFG_HOLD    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [COEF_W-1:0] attack_coef;
    logic [COEF_W-1:0] release_coef;
    logic [COEF_W-1:0] peak_fall;
    logic [HOLD_W-1:0] hold_updates;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] peak;
    logic [HOLD_W-1:0]  hold;
  } meter_state_t;

  function automatic logic [COEF_W-1:0] sat_coef(input logic [COEF_W-1:0] c);
    sat_coef = (c > COEF_ONE) ? COEF_ONE : c;
  endfunction

endpackage

@@ src/mbph_if.sv @@
// Handshake interfaces for target items and meter result items.
// Depends on mbph_pkg.
interface mbph_target_if;
  import mbph_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [TARGET_W-1:0] target_level;

  modport source (output valid, output target_level, input ready);
  modport sink (input valid, input target_level, output ready);
endinterface

interface mbph_meter_if;
  import mbph_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] meter_level;
  logic [LEVEL_W-1:0] peak_level;

  modport source (output valid, output meter_level, output peak_level, input ready);
  modport sink (input valid, input meter_level, input peak_level, output ready);
endinterface

@@ src/mbph_cfg_regs.sv @@
// Configuration registers with their reset values and write decode.
// Depends on mbph_pkg.
module mbph_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mbph_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mbph_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output mbph_pkg::cfg_t                     cfg_o
);
  import mbph_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_coef  <= ATTACK_RST;
      cfg_q.release_coef <= RELEASE_RST;
      cfg_q.peak_fall    <= FALL_RST;
      cfg_q.hold_updates <= HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_ATTACK:  cfg_q.attack_coef  <= cfg_data_i;
        CFG_RELEASE: cfg_q.release_coef <= cfg_data_i;
        CFG_FALL:    cfg_q.peak_fall    <= cfg_data_i;
        CFG_HOLD:    cfg_q.hold_updates <= cfg_data_i[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/mbph_update.sv @@
// Combinational ballistics update: one-pole level step, peak hold and fall.
// Depends on mbph_pkg.
module mbph_update (
  input  mbph_pkg::cfg_t                        cfg_i,
  input  mbph_pkg::meter_state_t                state_i,
  input  logic signed [mbph_pkg::TARGET_W-1:0]  target_i,
  output mbph_pkg::meter_state_t                state_o
);
  import mbph_pkg::*;

  localparam int DIFF_W = LEVEL_W + 2;
  localparam int PROD_W = DIFF_W + COEF_W + 1;
  localparam int FALL_W = LEVEL_W + COEF_W;

  logic [LEVEL_W-1:0]       target;
  logic [COEF_W-1:0]        coef;
  logic [COEF_W-1:0]        fall;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] step;
  logic signed [DIFF_W:0]   sum;
  logic [LEVEL_W-1:0]       new_level;
  logic [FALL_W-1:0]        fall_prod;
  logic [LEVEL_W:0]         fallen;

  always_comb begin
    target = target_i[TARGET_W-1] ? '0 : target_i[LEVEL_W-1:0];
    coef   = sat_coef((target > state_i.level) ? cfg_i.attack_coef : cfg_i.release_coef);
    fall   = sat_coef(cfg_i.peak_fall);

    diff = $signed({2'b00, target}) - $signed({2'b00, state_i.level});
    prod = PROD_W'(diff) * $signed({{(PROD_W-COEF_W){1'b0}}, coef});
    step = prod >>> FRAC_BITS;
    sum  = $signed({3'b000, state_i.level}) + $signed({step[DIFF_W-1], step[DIFF_W-1:0]});

    if (sum < 0) begin
      new_level = '0;
    end else if (sum > $signed({3'b000, LEVEL_MAX})) begin
      new_level = LEVEL_MAX;
    end else begin
      new_level = sum[LEVEL_W-1:0];
    end

    fall_prod = {{COEF_W{1'b0}}, state_i.peak} * {{LEVEL_W{1'b0}}, fall};
    fallen    = fall_prod[LEVEL_W+FRAC_BITS:FRAC_BITS];

    state_o.level = new_level;
    state_o.peak  = state_i.peak;
    state_o.hold  = state_i.hold;
    if (new_level >= state_i.peak) begin
      state_o.peak = new_level;
      state_o.hold = cfg_i.hold_updates;
    end else if (state_i.hold != '0) begin
      state_o.hold = state_i.hold - HOLD_W'(1);
    end else if (fallen < {1'b0, new_level}) begin
      state_o.peak = new_level;
    end else begin
      state_o.peak = fallen[LEVEL_W-1:0];
    end
  end

endmodule

@@ src/meter_ballistics_peak_hold_core.sv @@
// Level meter ballistics with peak hold and peak fall: top level.
// Depends on mbph_pkg, mbph_if, mbph_cfg_regs and mbph_update.
//
// Usage: each item on target_in is one Q2.16 target level; negative targets
// count as zero. For each item one result item appears on meter_out with the
// smoothed level and the held or falling peak.
// Configuration (attack coefficient, release coefficient, peak fall factor and
// hold length, in that order of index) is written through cfg_we_i, cfg_idx_i
// and cfg_data_i; the user must write it only while the block is idle, which
// the block itself does not enforce.
// An item accepted into the input register passes the update logic, which
// writes the level, peak and hold state together with the result register.
// The state update loop takes one item per cycle unless the receiver stalls.
// Reset clears the level, peak and hold state and empties both registers;
// configuration returns to its default values.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more item before ready drops.
module meter_ballistics_peak_hold_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  mbph_target_if.sink                      target_in,
  mbph_meter_if.source                     meter_out,
  input  logic                             cfg_we_i,
  input  logic [mbph_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mbph_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mbph_pkg::*;

  cfg_t                       cfg;
  meter_state_t               state_q;
  meter_state_t               state_d;
  logic                       in_valid_q;
  logic signed [TARGET_W-1:0] target_q;
  logic                       out_valid_q;
  logic [LEVEL_W-1:0]         level_out_q;
  logic [LEVEL_W-1:0]         peak_out_q;
  logic                       advance;
  logic                       fire;

  mbph_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mbph_update u_update (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .target_i (target_q),
    .state_o  (state_d)
  );

  assign advance         = !out_valid_q || meter_out.ready;
  assign fire            = in_valid_q && advance;
  assign target_in.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (target_in.ready) begin
        in_valid_q <= target_in.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (target_in.ready && target_in.valid) begin
      target_q <= target_in.target_level;
    end
    if (fire) begin
      level_out_q <= state_d.level;
      peak_out_q  <= state_d.peak;
    end
  end

  assign meter_out.valid       = out_valid_q;
  assign meter_out.meter_level = level_out_q;
  assign meter_out.peak_level  = peak_out_q;

endmodule
